// File: hw/rtl/tlpw_pkg.sv
// Shared types and constants for the two-level page walker.
// Used by two_level_page_walker and its testbench; depends on nothing else.
package tlpw_pkg;

  localparam int unsigned AddrWidth     = 32;
  localparam int unsigned LengthWidth   = 3;
  localparam int unsigned ShiftWidth    = 2;
  localparam int unsigned CfgIndexWidth = 1;
  localparam int unsigned OffsetWidth   = 12;
  localparam int unsigned DirShift      = 22;
  localparam int unsigned PageBytes     = 4096;
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QueuePtrWidth = 2;
  localparam int unsigned QueueCntWidth = 3;

  localparam logic [LengthWidth-1:0] MinLength = 3'd1;
  localparam logic [LengthWidth-1:0] MaxLength = 3'd4;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_DIR  = 2'd1,
    PHASE_PTE  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TABLE_READ = 2'd0,
    KIND_SEGMENT    = 2'd1,
    KIND_FAULT      = 2'd2
  } kind_t;

  typedef enum logic {
    OP_REQUEST    = 1'b0,
    OP_TABLE_WORD = 1'b1
  } op_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_PAGING_ENABLE  = 1'b0,
    REG_DIRECTORY_BASE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    kind_t                  kind;
    logic [AddrWidth-1:0]   address;
    logic [LengthWidth-1:0] seg_len;
    logic [ShiftWidth-1:0]  shift;
    logic                   last;
  } result_t;

endpackage

// File: hw/rtl/two_level_page_walker.sv
// Top level of the two-level page walker: input register, walk logic and result queue.
// Depends on tlpw_pkg for types and constants.

// The walker takes one input word per cycle while its result queue has room: the word is
// first captured in an input register, then the walk logic works out its results in one
// pass and writes them into a four-entry result queue whose head drives the result port.
// A request with paging off gives one physical segment; with paging on it gives a
// directory read, and each table word returned gives a page table read, a segment, or a
// fault. A page table word for an access that crosses a page boundary gives two results
// (the first segment and the next directory read), which the result port hands out one
// after the other. The input register only moves on while the queue has room for two
// results, so the sustained rate of one word per cycle is set by the result port draining
// one result per cycle. Requests that arrive during a walk and table words that arrive
// while idle are consumed without a result.
module two_level_page_walker (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               config_write,
  input  logic [tlpw_pkg::CfgIndexWidth-1:0] config_index,
  input  logic [tlpw_pkg::AddrWidth-1:0]     config_data,
  // request channel
  input  logic                               request_valid,
  output logic                               request_ready,
  input  logic                               operation,
  input  logic [tlpw_pkg::AddrWidth-1:0]     virtual_address,
  input  logic [tlpw_pkg::LengthWidth-1:0]   access_length,
  input  logic [tlpw_pkg::AddrWidth-1:0]     table_word,
  // result channel
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [1:0]                         result_kind,
  output logic [tlpw_pkg::AddrWidth-1:0]     address,
  output logic [tlpw_pkg::LengthWidth-1:0]   segment_length,
  output logic [tlpw_pkg::ShiftWidth-1:0]    data_shift_bytes,
  output logic                               last
);

  // Configuration registers.
  logic                           paging_enable;
  logic [tlpw_pkg::AddrWidth-1:0] directory_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      paging_enable  <= 1'b0;
      directory_base <= '0;
    end else if (config_write) begin
      case (tlpw_pkg::cfg_reg_t'(config_index))
        tlpw_pkg::REG_PAGING_ENABLE:  paging_enable  <= config_data[0];
        tlpw_pkg::REG_DIRECTORY_BASE: directory_base <= config_data;
        default: ;
      endcase
    end
  end

  // Input register: holds one accepted word until the walk logic consumes it.
  logic                             stage_valid;
  tlpw_pkg::op_t                    stage_op;
  logic [tlpw_pkg::AddrWidth-1:0]   stage_va;
  logic [tlpw_pkg::LengthWidth-1:0] stage_len;
  logic [tlpw_pkg::AddrWidth-1:0]   stage_word;

  // Result queue bookkeeping.
  tlpw_pkg::result_t                  queue [tlpw_pkg::QueueDepth];
  logic [tlpw_pkg::QueuePtrWidth-1:0] wr_ptr;
  logic [tlpw_pkg::QueuePtrWidth-1:0] rd_ptr;
  logic [tlpw_pkg::QueueCntWidth-1:0] count;

  // The stored word is worked on only when the queue can take two results.
  logic stage_proc;
  assign stage_proc    = stage_valid &&
                         (count <= tlpw_pkg::QueueCntWidth'(tlpw_pkg::QueueDepth - 2));
  assign request_ready = !stage_valid || stage_proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (request_ready) begin
      stage_valid <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request_ready && request_valid) begin
      stage_op   <= tlpw_pkg::op_t'(operation);
      stage_va   <= virtual_address;
      stage_len  <= access_length;
      stage_word <= table_word;
    end
  end

  // Walk state.
  tlpw_pkg::phase_t                 phase, phase_next;
  logic [tlpw_pkg::AddrWidth-1:0]   pending_address, pending_address_next;
  logic [tlpw_pkg::LengthWidth-1:0] pending_length, pending_length_next;
  logic [tlpw_pkg::ShiftWidth-1:0]  done_bytes, done_bytes_next;

  // Shared arithmetic for the current word.
  logic [tlpw_pkg::LengthWidth-1:0] len_fixed;
  logic                             present;
  logic [tlpw_pkg::OffsetWidth-1:0] offset;
  logic [tlpw_pkg::LengthWidth-1:0] remaining;
  logic [tlpw_pkg::OffsetWidth:0]   room;
  logic [tlpw_pkg::LengthWidth-1:0] seg;
  logic                             seg_final;
  logic [tlpw_pkg::AddrWidth-1:0]   next_va;
  logic [tlpw_pkg::AddrWidth-1:0]   dir_addr_new;
  logic [tlpw_pkg::AddrWidth-1:0]   dir_addr_next_page;
  logic [tlpw_pkg::AddrWidth-1:0]   pte_addr;
  logic [tlpw_pkg::AddrWidth-1:0]   phys_addr;

  always_comb begin
    if (stage_len == '0) begin
      len_fixed = tlpw_pkg::MinLength;
    end else if (stage_len > tlpw_pkg::MaxLength) begin
      len_fixed = tlpw_pkg::MaxLength;
    end else begin
      len_fixed = stage_len;
    end
  end

  assign present   = stage_word[0];
  assign offset    = pending_address[tlpw_pkg::OffsetWidth-1:0];
  assign remaining = pending_length - tlpw_pkg::LengthWidth'(done_bytes);
  assign room      = (tlpw_pkg::OffsetWidth+1)'(tlpw_pkg::PageBytes) -
                     {1'b0, offset};
  // Remaining is at most four, so a narrow room only matters near the page end.
  assign seg       = ({{(tlpw_pkg::OffsetWidth+1-tlpw_pkg::LengthWidth){1'b0}}, remaining}
                      < room) ? remaining : room[tlpw_pkg::LengthWidth-1:0];
  assign seg_final = ({2'b00, done_bytes} + {1'b0, seg}) >= {1'b0, pending_length};
  assign next_va   = pending_address + tlpw_pkg::AddrWidth'(seg);

  assign dir_addr_new       = directory_base +
                              {{(tlpw_pkg::DirShift-2){1'b0}},
                               stage_va[tlpw_pkg::AddrWidth-1:tlpw_pkg::DirShift], 2'b00};
  assign dir_addr_next_page = directory_base +
                              {{(tlpw_pkg::DirShift-2){1'b0}},
                               next_va[tlpw_pkg::AddrWidth-1:tlpw_pkg::DirShift], 2'b00};
  assign pte_addr  = {stage_word[tlpw_pkg::AddrWidth-1:tlpw_pkg::OffsetWidth],
                      {tlpw_pkg::OffsetWidth{1'b0}}} +
                     {{(tlpw_pkg::AddrWidth-tlpw_pkg::OffsetWidth){1'b0}},
                      pending_address[tlpw_pkg::DirShift-1:tlpw_pkg::OffsetWidth], 2'b00};
  assign phys_addr = {stage_word[tlpw_pkg::AddrWidth-1:tlpw_pkg::OffsetWidth], offset};

  // Next state of the walk.
  always_comb begin
    phase_next           = phase;
    pending_address_next = pending_address;
    pending_length_next  = pending_length;
    done_bytes_next      = done_bytes;
    if (stage_proc) begin
      case (phase)
        tlpw_pkg::PHASE_IDLE: begin
          if (stage_op == tlpw_pkg::OP_REQUEST && paging_enable) begin
            phase_next           = tlpw_pkg::PHASE_DIR;
            pending_address_next = stage_va;
            pending_length_next  = len_fixed;
            done_bytes_next      = '0;
          end
        end
        tlpw_pkg::PHASE_DIR: begin
          if (stage_op == tlpw_pkg::OP_TABLE_WORD) begin
            phase_next = present ? tlpw_pkg::PHASE_PTE : tlpw_pkg::PHASE_IDLE;
          end
        end
        tlpw_pkg::PHASE_PTE: begin
          if (stage_op == tlpw_pkg::OP_TABLE_WORD) begin
            if (!present || seg_final) begin
              phase_next = tlpw_pkg::PHASE_IDLE;
            end else begin
              phase_next           = tlpw_pkg::PHASE_DIR;
              done_bytes_next      = done_bytes + seg[tlpw_pkg::ShiftWidth-1:0];
              pending_address_next = next_va;
            end
          end
        end
        default: phase_next = tlpw_pkg::PHASE_IDLE;
      endcase
    end
  end

  // Results of the current word: how many, and their contents.
  logic [1:0]        res_count;
  tlpw_pkg::result_t res0, res1;

  always_comb begin
    res_count = 2'd0;
    res0      = '{kind: tlpw_pkg::KIND_TABLE_READ, address: '0, seg_len: '0,
                  shift: '0, last: 1'b0};
    res1      = '{kind: tlpw_pkg::KIND_TABLE_READ, address: dir_addr_next_page,
                  seg_len: '0, shift: '0, last: 1'b0};
    if (stage_proc) begin
      case (phase)
        tlpw_pkg::PHASE_IDLE: begin
          if (stage_op == tlpw_pkg::OP_REQUEST) begin
            res_count = 2'd1;
            if (paging_enable) begin
              res0.address = dir_addr_new;
            end else begin
              res0 = '{kind: tlpw_pkg::KIND_SEGMENT, address: stage_va, seg_len: len_fixed,
                       shift: '0, last: 1'b1};
            end
          end
        end
        tlpw_pkg::PHASE_DIR: begin
          if (stage_op == tlpw_pkg::OP_TABLE_WORD) begin
            res_count = 2'd1;
            if (present) begin
              res0.address = pte_addr;
            end else begin
              res0 = '{kind: tlpw_pkg::KIND_FAULT, address: pending_address, seg_len: '0,
                       shift: '0, last: 1'b1};
            end
          end
        end
        tlpw_pkg::PHASE_PTE: begin
          if (stage_op == tlpw_pkg::OP_TABLE_WORD) begin
            if (!present) begin
              res_count = 2'd1;
              res0 = '{kind: tlpw_pkg::KIND_FAULT, address: pending_address, seg_len: '0,
                       shift: '0, last: 1'b1};
            end else begin
              res_count = seg_final ? 2'd1 : 2'd2;
              res0 = '{kind: tlpw_pkg::KIND_SEGMENT, address: phys_addr, seg_len: seg,
                       shift: done_bytes, last: seg_final};
            end
          end
        end
        default: res_count = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tlpw_pkg::PHASE_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    pending_address <= pending_address_next;
    pending_length  <= pending_length_next;
    done_bytes      <= done_bytes_next;
  end

  // Result queue: up to two writes and one read per cycle.
  logic pop;
  assign pop = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tlpw_pkg::QueuePtrWidth'(res_count);
      rd_ptr <= rd_ptr + tlpw_pkg::QueuePtrWidth'(pop);
      count  <= count + tlpw_pkg::QueueCntWidth'(res_count) -
                tlpw_pkg::QueueCntWidth'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (res_count != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (res_count == 2'd2) begin
      queue[wr_ptr + tlpw_pkg::QueuePtrWidth'(1)] <= res1;
    end
  end

  tlpw_pkg::result_t head;
  assign head             = queue[rd_ptr];
  assign result_valid     = (count != '0);
  assign result_kind      = head.kind;
  assign address          = head.address;
  assign segment_length   = head.seg_len;
  assign data_shift_bytes = head.shift;
  assign last             = head.last;

  // The queue never overflows.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= tlpw_pkg::QueueCntWidth'(tlpw_pkg::QueueDepth))
    else $error("result queue overflow");

  // Only a page table word can give two results.
  a_two_only_pte: assert property (@(posedge clk) disable iff (rst)
    (res_count == 2'd2) |-> (phase == tlpw_pkg::PHASE_PTE))
    else $error("two results outside the page table phase");

  // A fault always ends the walk.
  a_fault_idle: assert property (@(posedge clk) disable iff (rst)
    (res_count != 2'd0 && res0.kind == tlpw_pkg::KIND_FAULT) |=>
    (phase == tlpw_pkg::PHASE_IDLE))
    else $error("walk continued after a fault");

  // Only segments carry a length.
  a_len_segment: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind != tlpw_pkg::KIND_SEGMENT) |-> (segment_length == '0))
    else $error("length on a non-segment result");

endmodule

// File: sim/two_level_page_walker_tb.sv
// Self-checking testbench for two_level_page_walker: directed walks, then random traffic.
// Depends on tlpw_pkg and the two_level_page_walker RTL; needs nothing else to run.
module two_level_page_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpw_pkg::*;

  // Clock and the single reset at the start of the run.
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Block inputs, all at known values from time zero.
  logic        config_write    = 1'b0;
  cfg_reg_t    config_index    = REG_PAGING_ENABLE;
  logic [31:0] config_data     = 32'd0;
  logic        request_valid   = 1'b0;
  logic        operation       = 1'b0;
  logic [31:0] virtual_address = 32'd0;
  logic [2:0]  access_length   = 3'd0;
  logic [31:0] table_word      = 32'd0;
  logic        result_ready    = 1'b0;

  // Block outputs.
  logic        request_ready;
  logic        result_valid;
  logic [1:0]  result_kind;
  logic [31:0] address;
  logic [2:0]  segment_length;
  logic [1:0]  data_shift_bytes;
  logic        last;

  // Our own copy of the walker's registers and walk state. It is updated at the
  // clock edge at which a word or a register write is taken by the block.
  logic        paging_on   = 1'b0;
  logic [31:0] dir_base    = 32'd0;
  phase_t      walk_phase  = PHASE_IDLE;
  logic [31:0] walk_addr   = 32'd0;
  logic [2:0]  walk_len    = 3'd0;
  logic [1:0]  walk_done   = 2'd0;

  // Results the walker still owes us, oldest first.
  result_t     walk_results[$];

  int          error_count = 0;

  // Idling controls: the source may pause between words, the sink may stall.
  bit          source_gaps = 1'b0;
  bit          sink_stalls = 1'b0;
  int          stall_left  = 0;

  two_level_page_walker DUT (
    .clk             (clk),
    .rst             (rst),
    .config_write    (config_write),
    .config_index    (config_index),
    .config_data     (config_data),
    .request_valid   (request_valid),
    .request_ready   (request_ready),
    .operation       (operation),
    .virtual_address (virtual_address),
    .access_length   (access_length),
    .table_word      (table_word),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .result_kind     (result_kind),
    .address         (address),
    .segment_length  (segment_length),
    .data_shift_bytes(data_shift_bytes),
    .last            (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_result(kind_t kind, logic [31:0] addr, logic [2:0] len,
                                      logic [1:0] shift, logic last_flag);
    result_t item;
    item.kind    = kind;
    item.address = addr;
    item.seg_len = len;
    item.shift   = shift;
    item.last    = last_flag;
    walk_results.push_back(item);
  endfunction

  // Directory entry address for a virtual address: base plus the top ten bits times
  // four, wrapping at 32 bits.
  function automatic logic [31:0] dir_entry(logic [31:0] va);
    return dir_base + {20'd0, va[31:22], 2'b00};
  endfunction

  // Advances the walk by one accepted word and queues the results it causes.
  function automatic void walk_step(op_t op, logic [31:0] va, logic [2:0] len,
                                    logic [31:0] word);
    logic [2:0]  size;
    logic [11:0] offset;
    logic [12:0] remaining;
    logic [12:0] room;
    logic [12:0] seg;
    logic [31:0] phys;
    // Out-of-range lengths are clamped into one to four bytes.
    size = (len == 3'd0) ? MinLength : ((len > MaxLength) ? MaxLength : len);
    if (op == OP_REQUEST) begin
      // A request during a walk is dropped without a result.
      if (walk_phase != PHASE_IDLE) return;
      if (!paging_on) begin
        // Untranslated: one segment, even across a page boundary.
        push_result(KIND_SEGMENT, va, size, 2'd0, 1'b1);
        return;
      end
      walk_addr  = va;
      walk_len   = size;
      walk_done  = 2'd0;
      walk_phase = PHASE_DIR;
      push_result(KIND_TABLE_READ, dir_entry(va), 3'd0, 2'd0, 1'b0);
    end else if (walk_phase == PHASE_DIR) begin
      if (!word[0]) begin
        walk_phase = PHASE_IDLE;
        push_result(KIND_FAULT, walk_addr, 3'd0, 2'd0, 1'b1);
      end else begin
        walk_phase = PHASE_PTE;
        push_result(KIND_TABLE_READ, {word[31:12], 12'd0} + {20'd0, walk_addr[21:12], 2'b00},
                    3'd0, 2'd0, 1'b0);
      end
    end else if (walk_phase == PHASE_PTE) begin
      offset    = walk_addr[11:0];
      remaining = {10'd0, walk_len} - {11'd0, walk_done};
      room      = 13'd4096 - {1'b0, offset};
      seg       = (remaining < room) ? remaining : room;
      if (!word[0]) begin
        walk_phase = PHASE_IDLE;
        push_result(KIND_FAULT, walk_addr, 3'd0, 2'd0, 1'b1);
        return;
      end
      phys = {word[31:12], 12'd0} + {20'd0, offset};
      if ({11'd0, walk_done} + seg >= {10'd0, walk_len}) begin
        walk_phase = PHASE_IDLE;
        push_result(KIND_SEGMENT, phys, seg[2:0], walk_done, 1'b1);
      end else begin
        // The access runs over the page end: emit the first part, then walk the
        // next page from the first byte past it.
        push_result(KIND_SEGMENT, phys, seg[2:0], walk_done, 1'b0);
        walk_done  = walk_done + seg[1:0];
        walk_addr  = walk_addr + {19'd0, seg};
        walk_phase = PHASE_DIR;
        push_result(KIND_TABLE_READ, dir_entry(walk_addr), 3'd0, 2'd0, 1'b0);
      end
    end
    // A table word while idle is dropped without a result.
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result sink. Outputs are sampled at the edge before anything is updated, so a
  // word counts as taken exactly when valid and ready were both high at that edge.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (walk_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d address %h",
                 $time, result_kind, address);
        error_count++;
      end else begin
        want = walk_results.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(result_kind));
        check_field("address", want.address, address);
        check_field("segment_length", 32'(want.seg_len), 32'(segment_length));
        check_field("data_shift_bytes", 32'(want.shift), 32'(data_shift_bytes));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // Back-pressure on the result side: random stalls of random length when enabled.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_ready <= 1'b0;
    end else if (sink_stalls && ($urandom_range(0, 3) == 0)) begin
      stall_left   <= pick_gap();
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Sends one word and waits until it is taken. Valid is left high afterwards: the
  // next call either keeps it high for a back-to-back word or drops it for a gap,
  // so valid never gets two assignments in the same time step.
  task automatic send_word(op_t op, logic [31:0] va, logic [2:0] len, logic [31:0] word);
    int gap;
    gap = source_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request_valid   <= 1'b1;
    operation       <= op;
    virtual_address <= va;
    access_length   <= len;
    table_word      <= word;
    @(posedge clk);
    while (!request_ready) @(posedge clk);
    walk_step(op, va, len, word);
  endtask

  // Stops sending, waits for every owed result, then gives dropped words still in
  // the pipeline time to pass through before the block is treated as idle.
  task automatic drain_results();
    request_valid <= 1'b0;
    while (walk_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Register writes are only made while the walker is idle.
  task automatic write_register(cfg_reg_t index, logic [31:0] data);
    config_write <= 1'b1;
    config_index <= index;
    config_data  <= data;
    @(posedge clk);
    config_write <= 1'b0;
    case (index)
      REG_PAGING_ENABLE:  paging_on = data[0];
      REG_DIRECTORY_BASE: dir_base  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Paging off: addresses pass straight through, lengths are clamped, and a
  // table word with no walk in progress is dropped.
  task automatic test_passthrough();
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    write_register(REG_PAGING_ENABLE, 32'd0);
    send_word(OP_REQUEST, 32'h0000_0000, 3'd1, 32'h0000_0000);
    // Crosses a page boundary but still comes out as one segment.
    send_word(OP_REQUEST, 32'hffff_ffff, 3'd4, 32'hffff_ffff);
    send_word(OP_REQUEST, 32'h0000_1234, 3'd0, 32'h0000_0000);
    send_word(OP_REQUEST, 32'hffff_fffe, 3'd7, 32'hffff_ffff);
    send_word(OP_TABLE_WORD, 32'hffff_ffff, 3'd7, 32'hffff_ffff);
    drain_results();
  endtask

  // Paging on with a directory near the top of memory, so that table addresses wrap.
  task automatic test_walk_cases();
    write_register(REG_PAGING_ENABLE, 32'd1);
    write_register(REG_DIRECTORY_BASE, 32'hffff_fffc);
    // Highest byte: the directory entry address wraps.
    send_word(OP_REQUEST, 32'hffff_ffff, 3'd1, 32'h0000_0000);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'hffff_ffff);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'hffff_ffff);
    // Directory entry not present.
    send_word(OP_REQUEST, 32'h1234_5678, 3'd2, 32'hffff_ffff);
    send_word(OP_TABLE_WORD, 32'hffff_ffff, 3'd7, 32'h0000_0000);
    // Page table entry not present.
    send_word(OP_REQUEST, 32'h0000_0000, 3'd4, 32'h0000_0000);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'h0000_0001);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'hffff_fffe);
    // Split across two pages, with a request arriving mid-walk that must be dropped.
    send_word(OP_REQUEST, 32'h0040_0ffe, 3'd4, 32'h0000_0000);
    send_word(OP_REQUEST, 32'h0000_0000, 3'd1, 32'h0000_0000);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'h0000_1001);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'habcd_e001);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'h0000_2003);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'h1357_9001);
    // Split where the second page wraps to address zero and then faults.
    send_word(OP_REQUEST, 32'hffff_fffd, 3'd4, 32'h0000_0000);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'h0000_3001);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'h0004_5001);
    send_word(OP_TABLE_WORD, 32'h0000_0000, 3'd0, 32'hffff_fffe);
    drain_results();
  endtask

  // Whole accesses with random content under several register settings. Most walks
  // run to the end; a few entries are not present, and stray words are mixed in.
  task automatic test_random_traffic();
    logic        enable;
    logic [31:0] base;
    logic [31:0] va;
    logic [31:0] word;
    logic [2:0]  len;
    int          accesses;
    for (int setting = 0; setting < 6; setting++) begin
      enable = (setting % 3) != 2;
      base   = (setting == 0) ? 32'h0000_0000 :
               (setting == 1) ? 32'hffff_ffff : $urandom();
      write_register(REG_PAGING_ENABLE, {31'd0, enable});
      write_register(REG_DIRECTORY_BASE, base);
      accesses = enable ? 80 : 100;
      for (int n = 0; n < accesses; n++) begin
        // Change the idling pattern now and then, so that some stretches run flat out.
        if (n % 40 == 0) begin
          source_gaps = ($urandom_range(0, 1) == 1);
          sink_stalls = ($urandom_range(0, 1) == 1);
        end
        if ($urandom_range(0, 19) == 0)
          send_word(OP_TABLE_WORD, $urandom(), 3'($urandom_range(0, 7)), $urandom());
        va = $urandom();
        // Push a third of the accesses against the page end so that many split.
        if ($urandom_range(0, 2) == 0) va[11:0] = 12'hffc | 12'($urandom_range(0, 3));
        len = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                          : 3'($urandom_range(0, 7));
        send_word(OP_REQUEST, va, len, $urandom());
        while (walk_phase != PHASE_IDLE) begin
          if ($urandom_range(0, 19) == 0)
            send_word(OP_REQUEST, $urandom(), 3'($urandom_range(0, 7)), $urandom());
          word    = $urandom();
          word[0] = ($urandom_range(0, 99) < 93);
          send_word(OP_TABLE_WORD, $urandom(), 3'($urandom_range(0, 7)), word);
        end
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_walk_cases();
    test_random_traffic();
    if (error_count == 0) begin
      $display("two_level_page_walker_tb: PASS");
    end else begin
      $display("two_level_page_walker_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("two_level_page_walker_tb: FAIL");
    $finish;
  end

endmodule

// File: two_level_page_walker.f
hw/rtl/tlpw_pkg.sv
hw/rtl/two_level_page_walker.sv
sim/two_level_page_walker_tb.sv
